// ----- sv/smhc_pkg.sv -----
`default_nettype none
package smhc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int ENTRY_W     = 192;

  localparam logic [31:0] PR1 = 32'd2654435761;
  localparam logic [31:0] PR2 = 32'd2246822519;
  localparam logic [31:0] PR3 = 32'd3266489917;
  localparam logic [31:0] PR4 = 32'd668265263;
  localparam logic [31:0] PR5 = 32'd374761393;

  localparam logic [2:0] MODE_FULL       = 3'd0;
  localparam logic [2:0] MODE_NO_WORD0   = 3'd1;
  localparam logic [2:0] MODE_DRAW_INST  = 3'd2;
  localparam logic [2:0] MODE_ENTRY_PRIM = 3'd3;
  localparam logic [2:0] MODE_CH0        = 3'd4;
  localparam logic [2:0] MODE_CH1        = 3'd5;
  localparam logic [2:0] MODE_CH2        = 3'd6;

  localparam logic [1:0] CFG_COLOR_MODE = 2'd0;
  localparam logic [1:0] CFG_HASH_SEED  = 2'd1;
  localparam logic [1:0] CFG_ENTRIES    = 2'd2;

  // registers from table read data to hash result
  localparam int HASH_LAT = 8;

  typedef struct packed {
    logic [2:0]  color_mode;
    logic [31:0] hash_seed;
  } hash_cfg_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage
`default_nettype wire

// ----- sv/smhc_table.sv -----
`default_nettype none
module smhc_table
  import smhc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_addr,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/smhc_hash.sv -----
`default_nettype none
module smhc_hash
  import smhc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire hash_cfg_t          cfg,
  input  wire logic [ENTRY_W-1:0] entry,
  input  wire logic [31:0]        draw_number,
  input  wire logic [31:0]        instance_id,
  input  wire logic [31:0]        primitive_id,
  output logic      [31:0]        hash
);

  logic        long_in;
  logic [1:0]  steps;
  logic [4:0]  len;
  logic [31:0] lw [4];
  logic [31:0] tw [3];

  logic [31:0] lp [4];
  logic [31:0] lv [4];
  logic [31:0] tp1 [3];
  logic [31:0] tp2 [3];
  logic [31:0] tp3 [3];
  logic [31:0] tp4 [3];
  logic [31:0] tp5 [3];
  logic [31:0] h3, h4, h5, h6;
  logic [31:0] f1, f2;

  always_comb begin
    long_in = 1'b1;
    steps   = 2'd2;
    len     = 5'd24;
    lw[0] = entry[31:0];
    lw[1] = entry[63:32];
    lw[2] = entry[95:64];
    lw[3] = entry[127:96];
    tw[0] = entry[159:128];
    tw[1] = entry[191:160];
    tw[2] = primitive_id;
    case (cfg.color_mode)
      MODE_NO_WORD0: begin
        lw[0] = '0;
        lw[1] = '0;
      end
      MODE_DRAW_INST: begin
        long_in = 1'b0;
        len     = 5'd8;
        tw[0]   = draw_number;
        tw[1]   = instance_id;
      end
      MODE_ENTRY_PRIM: begin
        steps = 2'd3;
        len   = 5'd28;
      end
      MODE_CH0, MODE_CH1, MODE_CH2: begin
        long_in = 1'b0;
        steps   = 2'd1;
        len     = 5'd4;
        tw[0]   = (cfg.color_mode == MODE_CH0) ? draw_number :
                  (cfg.color_mode == MODE_CH1) ? instance_id : primitive_id;
      end
      default: begin
      end
    endcase
  end

  logic [31:0] v0 [4];
  assign v0[0] = cfg.hash_seed + PR1 + PR2;
  assign v0[1] = cfg.hash_seed + PR2;
  assign v0[2] = cfg.hash_seed;
  assign v0[3] = cfg.hash_seed - PR1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        lp[i] <= lw[i] * PR2;
        lv[i] <= rotl32(v0[i] + lp[i], 13) * PR1;
      end
      for (int i = 0; i < 3; i++) begin
        tp1[i] <= tw[i] * PR3;
        tp2[i] <= tp1[i];
        tp3[i] <= tp2[i];
        tp4[i] <= tp3[i];
        tp5[i] <= tp4[i];
      end
      h3 <= (long_in ? rotl32(lv[0], 1) + rotl32(lv[1], 7) + rotl32(lv[2], 12)
                       + rotl32(lv[3], 18)
                     : cfg.hash_seed + PR5) + {27'd0, len};
      h4 <= rotl32(h3 + tp3[0], 17) * PR4;
      h5 <= (steps >= 2'd2) ? rotl32(h4 + tp4[1], 17) * PR4 : h4;
      h6 <= (steps == 2'd3) ? rotl32(h5 + tp5[2], 17) * PR4 : h5;
      f1 <= (h6 ^ (h6 >> 15)) * PR2;
      f2 <= (f1 ^ (f1 >> 13)) * PR3;
    end
  end

  assign hash = f2 ^ (f2 >> 16);

endmodule
`default_nettype wire

// ----- sv/segment_metadata_hash_colorizer_core.sv -----
`default_nettype none
// Per-frame draw metadata table with XXH32 id colouring. Load requests
// (tuser 0) write one 192-bit entry; pixel requests (tuser 1) look up the
// entry at draw_number clamped to the last entry in use, hash the bytes
// picked by color_mode and return the colour (top byte 255) and the entry.
// One request is taken every cycle while the output is not stalled; a
// pixel's result passes through the table read, eight hash stages (two
// lane stages, the lane merge, three dependent tail multiplies, two
// finalisation multiplies) and the output register. The whole pipeline
// holds while the output is stalled.
module segment_metadata_hash_colorizer_core
  import smhc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // entry_index, entry_word0, entry_word1, entry_word2, draw_number,
  // instance_id, primitive_id, zero pad
  input  wire logic [303:0] s_tdata,
  // action
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pixel_color, meta_word0, meta_word1, meta_word2
  output logic      [223:0] m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  logic [2:0]       color_mode;
  logic [31:0]      hash_seed;
  logic [CNT_W-1:0] entries_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode     <= '0;
      hash_seed      <= '0;
      entries_in_use <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLOR_MODE: color_mode     <= cfg_data[2:0];
        CFG_HASH_SEED:  hash_seed      <= cfg_data;
        CFG_ENTRIES:    entries_in_use <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic advance, accept;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && advance;

  logic [IDX_W-1:0] in_index;
  logic [31:0]      in_draw, in_inst, in_prim;
  assign in_index = s_tdata[9:0];
  assign in_draw  = s_tdata[233:202];
  assign in_inst  = s_tdata[265:234];
  assign in_prim  = s_tdata[297:266];

  // clamp the lookup to the last entry in use
  logic [CNT_W-1:0] n, n_last;
  logic [IDX_W-1:0] rd_addr;
  always_comb begin
    n       = (entries_in_use > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_in_use;
    n_last  = n - CNT_W'(1);
    rd_addr = (in_draw < {21'd0, n_last}) ? in_draw[IDX_W-1:0] : n_last[IDX_W-1:0];
  end

  logic [ENTRY_W-1:0] entry_q;

  smhc_table u_table (
    .clk     (clk),
    .wr_en   (accept && !s_tuser),
    .wr_addr (in_index),
    .wr_data (s_tdata[201:10]),
    .rd_en   (accept && s_tuser),
    .rd_addr (rd_addr),
    .rd_data (entry_q)
  );

  logic        s1_valid, s1_empty;
  logic [31:0] s1_draw, s1_inst, s1_prim;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_empty <= (n == '0);
      s1_draw  <= in_draw;
      s1_inst  <= in_inst;
      s1_prim  <= in_prim;
    end
  end

  hash_cfg_t   hcfg;
  logic [31:0] hash;
  assign hcfg = '{color_mode: color_mode, hash_seed: hash_seed};

  smhc_hash u_hash (
    .clk          (clk),
    .en           (advance),
    .cfg          (hcfg),
    .entry        (entry_q),
    .draw_number  (s1_draw),
    .instance_id  (s1_inst),
    .primitive_id (s1_prim),
    .hash         (hash)
  );

  logic [HASH_LAT-1:0] vpipe, epipe;
  logic [ENTRY_W-1:0]  mpipe [HASH_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe    <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      vpipe    <= {vpipe[HASH_LAT-2:0], s1_valid};
      m_tvalid <= vpipe[HASH_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      epipe    <= {epipe[HASH_LAT-2:0], s1_empty};
      mpipe[0] <= entry_q;
      for (int i = 1; i < HASH_LAT; i++) begin
        mpipe[i] <= mpipe[i-1];
      end
      if (epipe[HASH_LAT-1]) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {mpipe[HASH_LAT-1], 8'hff, hash[23:0]};
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_segment_metadata_hash_colorizer_core.sv -----
`timescale 1ns / 1ps
module tb_segment_metadata_hash_colorizer_core;
  import smhc_pkg::*;

  // s_tdata layout, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] prim;
    logic [31:0] inst;
    logic [31:0] draw;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
    logic [9:0]  slot;
  } pix_req_t;

  // m_tdata layout, colour in the lowest bits
  typedef struct packed {
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
    logic [31:0] color;
  } pix_res_t;

  typedef struct {
    logic       is_cfg;
    logic [1:0] cfg_idx;
    logic [31:0] cfg_val;
    logic       act;
    pix_req_t   req;
    logic       has_exp;
    pix_res_t   exp;
  } stim_row_t;

  localparam int LOAD  = 0;
  localparam int PIXEL = 1;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEMS        = 950;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [303:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [223:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  segment_metadata_hash_colorizer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block's table and registers
  logic [63:0] tab_w0 [TABLE_DEPTH];
  logic [63:0] tab_w1 [TABLE_DEPTH];
  logic [63:0] tab_w2 [TABLE_DEPTH];
  bit          tab_loaded [TABLE_DEPTH];
  logic [2:0]  mode_reg = MODE_FULL;
  logic [31:0] seed_reg = '0;
  logic [10:0] entries_reg = '0;

  pix_res_t    colors_due[$];
  int          errors = 0;
  bit          quiet_phase = 0;
  bit          hold_req = 0;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] le32(input logic [7:0] b [28], input int p);
    return {b[p+3], b[p+2], b[p+1], b[p]};
  endfunction

  function automatic logic [31:0] xxh_round(input logic [31:0] v, input logic [31:0] w);
    logic [31:0] t;
    t = v + w * PR2;
    return rol32(t, 13) * PR1;
  endfunction

  function automatic logic [31:0] xxh32_bytes(input logic [7:0] b [28], input int len,
                                              input logic [31:0] seed);
    logic [31:0] v1, v2, v3, v4, h;
    int p;
    p = 0;
    if (len >= 16) begin
      v1 = seed + PR1 + PR2;
      v2 = seed + PR2;
      v3 = seed;
      v4 = seed - PR1;
      while (p + 16 <= len) begin
        v1 = xxh_round(v1, le32(b, p));
        v2 = xxh_round(v2, le32(b, p + 4));
        v3 = xxh_round(v3, le32(b, p + 8));
        v4 = xxh_round(v4, le32(b, p + 12));
        p += 16;
      end
      h = rol32(v1, 1) + rol32(v2, 7) + rol32(v3, 12) + rol32(v4, 18);
    end else begin
      h = seed + PR5;
    end
    h = h + len;
    while (p + 4 <= len) begin
      h = h + le32(b, p) * PR3;
      h = rol32(h, 17) * PR4;
      p += 4;
    end
    while (p < len) begin
      h = h + {24'd0, b[p]} * PR5;
      h = rol32(h, 11) * PR1;
      p++;
    end
    h = h ^ (h >> 15);
    h = h * PR2;
    h = h ^ (h >> 13);
    h = h * PR3;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic int live_entries();
    return (entries_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_reg);
  endfunction

  function automatic int lookup_slot(input logic [31:0] draw);
    int n;
    n = live_entries();
    return (draw < n - 1) ? int'(draw) : n - 1;
  endfunction

  function automatic pix_res_t colorize(input pix_req_t r);
    pix_res_t    res;
    logic [7:0]  b [28];
    logic [31:0] ch [3];
    logic [31:0] hv;
    int          slot, len;
    res = '0;
    if (live_entries() == 0) return res;
    slot = lookup_slot(r.draw);
    res.w0 = tab_w0[slot];
    res.w1 = tab_w1[slot];
    res.w2 = tab_w2[slot];
    ch[0] = r.draw;
    ch[1] = r.inst;
    ch[2] = r.prim;
    for (int i = 0; i < 28; i++) b[i] = 8'd0;
    for (int i = 0; i < 8; i++) begin
      b[i]      = res.w0[8*i +: 8];
      b[i + 8]  = res.w1[8*i +: 8];
      b[i + 16] = res.w2[8*i +: 8];
    end
    len = 24;
    case (mode_reg)
      MODE_NO_WORD0: for (int i = 0; i < 8; i++) b[i] = 8'd0;
      MODE_DRAW_INST: begin
        for (int i = 0; i < 4; i++) begin
          b[i]     = ch[0][8*i +: 8];
          b[i + 4] = ch[1][8*i +: 8];
        end
        len = 8;
      end
      MODE_ENTRY_PRIM: begin
        for (int i = 0; i < 4; i++) b[24 + i] = ch[2][8*i +: 8];
        len = 28;
      end
      MODE_CH0, MODE_CH1, MODE_CH2: begin
        for (int i = 0; i < 4; i++) b[i] = ch[mode_reg - MODE_CH0][8*i +: 8];
        len = 4;
      end
      default: ;
    endcase
    hv = xxh32_bytes(b, len, seed_reg);
    res.color = {8'hFF, hv[23:0]};
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // one request on the slave side; the shadow state advances on acceptance
  task automatic send_request(input logic act, input pix_req_t r, input logic has_exp,
                              input pix_res_t exp);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (act == LOAD) begin
      tab_w0[r.slot] = r.w0;
      tab_w1[r.slot] = r.w1;
      tab_w2[r.slot] = r.w2;
      tab_loaded[r.slot] = 1;
    end else begin
      colors_due.push_back(has_exp ? exp : colorize(r));
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_COLOR_MODE: mode_reg = val[2:0];
      CFG_HASH_SEED:  seed_reg = val;
      CFG_ENTRIES:    entries_reg = val[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic stim_row_t req_row(input logic act, input logic [9:0] slot,
                                        input logic [63:0] w0, input logic [63:0] w1,
                                        input logic [63:0] w2, input logic [31:0] draw,
                                        input logic [31:0] inst, input logic [31:0] prim);
    stim_row_t row;
    row = '{default: '0};
    row.act = act;
    row.req = '{pad: '0, prim: prim, inst: inst, draw: draw, w2: w2, w1: w1, w0: w0,
                slot: slot};
    return row;
  endfunction

  // receiver: random back-pressure, and one long hold on request
  initial begin
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pix_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (colors_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = colors_due.pop_front();
        if (got.color !== want.color) begin
          $display("%0t: pixel_color expected %h got %h", $time, want.color, got.color);
          errors++;
        end
        if (got.w0 !== want.w0) begin
          $display("%0t: meta_word0 expected %h got %h", $time, want.w0, got.w0);
          errors++;
        end
        if (got.w1 !== want.w1) begin
          $display("%0t: meta_word1 expected %h got %h", $time, want.w1, got.w1);
          errors++;
        end
        if (got.w2 !== want.w2) begin
          $display("%0t: meta_word2 expected %h got %h", $time, want.w2, got.w2);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t  rows[$];
    stim_row_t  row;
    pix_req_t   r;
    int         sent, phase, phase_len, n, k, slot;
    logic [31:0] draw;
    for (int i = 0; i < TABLE_DEPTH; i++) tab_loaded[i] = 0;

    // empty table: result is all zero
    row = req_row(PIXEL, 10'd0, '0, '0, '0, 32'd0, 32'd0, 32'd0);
    row.has_exp = 1'b1;
    rows.push_back(row);
    row = req_row(PIXEL, 10'h3FF, '1, '1, '1, '1, '1, '1);
    row.has_exp = 1'b1;
    rows.push_back(row);
    rows.push_back(req_row(LOAD, 10'd0, '0, '0, '0, '1, '1, '1));
    rows.push_back(req_row(LOAD, 10'h3FF, '1, '1, '1, '0, '0, '0));
    rows.push_back(req_row(LOAD, 10'd1, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                           64'h00FF00FF00FF00FF, 32'd0, 32'd0, 32'd0));
    rows.push_back(req_row(LOAD, 10'h155, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
                           64'h8000000000000001, 32'd0, 32'd0, 32'd0));
    rows.push_back(cfg_row(CFG_ENTRIES, 32'd1024));
    rows.push_back(req_row(PIXEL, 10'd0, '0, '0, '0, 32'd0, 32'd7, 32'd9));
    rows.push_back(req_row(PIXEL, 10'd0, '0, '0, '0, 32'd1023, '1, '1));
    rows.push_back(req_row(PIXEL, 10'd0, '0, '0, '0, 32'd1024, 32'd0, 32'd0));
    rows.push_back(req_row(PIXEL, 10'd0, '0, '0, '0, '1, 32'h12345678, 32'h9ABCDEF0));
    for (int m = MODE_NO_WORD0; m <= 7; m++) begin
      rows.push_back(cfg_row(CFG_COLOR_MODE, m));
      rows.push_back(req_row(PIXEL, 10'd0, '0, '0, '0, 32'd1, 32'hDEADBEEF, 32'hCAFEF00D));
    end
    rows.push_back(cfg_row(CFG_HASH_SEED, '1));
    rows.push_back(cfg_row(CFG_UNUSED, 32'hFFFFFFFF));
    rows.push_back(cfg_row(CFG_COLOR_MODE, MODE_ENTRY_PRIM));
    rows.push_back(req_row(PIXEL, 10'd0, '0, '0, '0, 32'h155, '1, '1));
    rows.push_back(cfg_row(CFG_ENTRIES, 32'd1));
    rows.push_back(req_row(PIXEL, 10'd0, '0, '0, '0, '1, '0, '0));
    // above the table depth saturates
    rows.push_back(cfg_row(CFG_ENTRIES, 32'h7FF));
    rows.push_back(req_row(PIXEL, 10'd0, '0, '0, '0, 32'h800, 32'd3, 32'd4));
    rows.push_back(cfg_row(CFG_ENTRIES, 32'd0));
    row = req_row(PIXEL, 10'd0, '0, '0, '0, 32'd5, 32'd5, 32'd5);
    row.has_exp = 1'b1;
    rows.push_back(row);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain_results();
        write_reg(rows[i].cfg_idx, rows[i].cfg_val);
      end else begin
        send_request(rows[i].act, rows[i].req, rows[i].has_exp, rows[i].exp);
      end
    end

    sent = rows.size();
    phase = 0;
    while (sent < ITEMS) begin
      drain_results();
      write_reg(CFG_COLOR_MODE, $urandom_range(0, 7));
      k = $urandom_range(0, 3);
      write_reg(CFG_HASH_SEED, (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFFFFFF : $urandom);
      k = $urandom_range(0, 9);
      n = (k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? 1024 : (k == 3) ? $urandom_range(0, 2047) :
          $urandom_range(2, 64);
      write_reg(CFG_ENTRIES, n);
      quiet_phase = (phase % 4 == 1);
      if (phase == 2) hold_req = 1;
      phase_len = $urandom_range(60, 120);
      if (phase_len > ITEMS - sent) phase_len = ITEMS - sent;
      for (int j = 0; j < phase_len; j++) begin
        r = '0;
        n = live_entries();
        k = $urandom_range(0, 9);
        r.w0 = rand_word();
        r.w1 = rand_word();
        r.w2 = rand_word();
        r.inst = $urandom;
        r.prim = $urandom;
        if (k < 2) begin
          slot = (n > 0 && k == 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 1023);
          r.slot = slot;
          r.draw = $urandom;
          send_request(LOAD, r, 1'b0, '0);
        end else begin
          draw = (k < 7) ? $urandom_range(0, n + 3) : $urandom;
          r.draw = draw;
          // never read a slot that was never loaded: load it first
          if (n > 0 && !tab_loaded[lookup_slot(draw)]) begin
            r.slot = lookup_slot(draw);
            send_request(LOAD, r, 1'b0, '0);
          end else begin
            send_request(PIXEL, r, 1'b0, '0);
          end
        end
        sent++;
      end
      phase++;
    end

    quiet_phase = 0;
    drain_results();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- segment_metadata_hash_colorizer_core.f -----
sv/smhc_pkg.sv
sv/smhc_table.sv
sv/smhc_hash.sv
sv/segment_metadata_hash_colorizer_core.sv
tb/tb_segment_metadata_hash_colorizer_core.sv
